@@ src/ugci_pkg.sv @@
// shared types and codes for the uniform grid cubic interpolator
package ugci_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_VALUE = 2'd1,
    OP_SLOPE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_BADIDX  = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  localparam logic [1:0] REG_GRID_MIN = 2'd0;
  localparam logic [1:0] REG_INV_SPC  = 2'd1;
  localparam logic [1:0] REG_COUNT    = 2'd2;

endpackage

@@ src/ugci_mulfrac.sv @@
// pipelined signed-by-fraction multiply, truncated toward zero
module ugci_mulfrac
  import ugci_pkg::*;
#(
  parameter int XW = 48,
  parameter int FB = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x,
  input  logic        [FB:0]   f,
  output logic signed [XW-1:0] y
);
  // magnitude times fraction, then shift and restore sign
  logic [XW-1:0]    mag;
  logic [XW+FB:0]   prod;
  logic             neg;
  logic [XW-1:0]    shifted;

  always_comb begin
    mag = x[XW-1] ? XW'(-x) : XW'(x);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= (XW+FB+1)'(mag) * (XW+FB+1)'(f);
      neg  <= x[XW-1];
    end
  end

  assign shifted = prod[FB +: XW];
  assign y = neg ? -$signed(shifted) : $signed(shifted);
endmodule

@@ src/uniform_grid_cubic_interpolator_top.sv @@
// top level: sample table, position scaling and catmull-rom evaluation pipeline
// throughput: one transaction per cycle; the whole pipeline advances together and
//   holds only while the output register is full and m_tready is low
// reset: synchronous active-high rst clears valid bits and restores registers to
//   grid_min 0, inverse_spacing 1.0, point_count 5; table contents stay undefined
module uniform_grid_cubic_interpolator_top
  import ugci_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[1:0], sample_index[11:2], sample_value[43:12], position[75:44], pad
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_value[31:0], status[33:32], pad
  output logic [39:0] m_tdata
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int XW = 48;
  localparam int NS = 8;

  // configuration registers
  logic signed [31:0] grid_min;
  logic        [31:0] inverse_spacing;
  logic        [10:0] point_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_min        <= '0;
      inverse_spacing <= 32'd65536;
      point_count     <= 11'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_MIN: grid_min        <= cfg_data;
        REG_INV_SPC:  inverse_spacing <= cfg_data;
        REG_COUNT:    point_count     <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // effective point count, clamped to five and the table depth
  logic [16:0] n_eff;
  always_comb begin
    if (point_count < 11'd5) n_eff = 17'd5;
    else if (17'(point_count) > 17'(TABLE_DEPTH)) n_eff = 17'(TABLE_DEPTH);
    else n_eff = 17'(point_count);
  end

  // global advance: pipeline moves when the output side can take a transaction
  logic en;
  logic [NS-1:0] vld;
  logic out_full;
  assign en = !out_full || m_tready;
  assign s_tready = en;

  // input fields
  op_t                op_in;
  logic [9:0]         sidx_in;
  logic signed [31:0] sval_in;
  logic signed [31:0] pos_in;
  assign op_in   = op_t'(s_tdata[1:0]);
  assign sidx_in = s_tdata[11:2];
  assign sval_in = s_tdata[43:12];
  assign pos_in  = s_tdata[75:44];
  logic acc;
  assign acc = s_tvalid && s_tready;

  // stage 1: offset from grid_min, write index check, below-grid check for queries
  op_t               s1_op;
  status_t           s1_st;
  logic [31:0]       s1_diff;
  logic [9:0]        s1_sidx;
  logic signed [31:0] s1_sval;
  logic signed [32:0] diff_w;
  assign diff_w = 33'(pos_in) - 33'(grid_min);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op   <= op_in;
      s1_diff <= diff_w[31:0];
      s1_sidx <= sidx_in;
      s1_sval <= sval_in;
      if (op_in == OP_WRITE && 17'(sidx_in) >= n_eff) s1_st <= ST_BADIDX;
      else if ((op_in == OP_VALUE || op_in == OP_SLOPE) && diff_w[32]) s1_st <= ST_OUTSIDE;
      else s1_st <= ST_OK;
    end
  end

  // stage 2: scale by the inverse spacing
  op_t        s2_op;
  status_t    s2_st;
  logic [63:0] s2_prod;
  logic [9:0]  s2_sidx;
  logic signed [31:0] s2_sval;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_op   <= s1_op;
      s2_st   <= s1_st;
      s2_sidx <= s1_sidx;
      s2_sval <= s1_sval;
      s2_prod <= 64'(s1_diff) * 64'(inverse_spacing);
    end
  end

  // stage 3: index and fraction, range check, neighbour addresses
  logic [63:0] t_w;
  logic [63:0] last_w;
  logic [47:0] i_raw;
  assign t_w    = s2_prod >> FRAC_BITS;
  assign last_w = 64'(n_eff - 17'd1) << FRAC_BITS;
  assign i_raw  = 48'(t_w >> FRAC_BITS);

  op_t             s3_op;
  status_t         s3_st;
  logic [FRAC_BITS:0] s3_f;
  logic [AW-1:0]   s3_i;
  logic            s3_first, s3_lastiv;
  logic [9:0]      s3_sidx;
  logic signed [31:0] s3_sval;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_op   <= s2_op;
      s3_sidx <= s2_sidx;
      s3_sval <= s2_sval;
      if ((s2_op == OP_VALUE || s2_op == OP_SLOPE) && s2_st == ST_OK && t_w > last_w)
        s3_st <= ST_OUTSIDE;
      else
        s3_st <= s2_st;
      if (48'(n_eff) - 48'd1 == i_raw) begin
        s3_i <= AW'(i_raw - 48'd1);
        s3_f <= (FRAC_BITS+1)'(1) << FRAC_BITS;
      end else begin
        s3_i <= AW'(i_raw);
        s3_f <= {1'b0, t_w[FRAC_BITS-1:0]};
      end
      s3_first  <= (i_raw == 48'd0);
      s3_lastiv <= (i_raw == 48'(n_eff) - 48'd2) || (48'(n_eff) - 48'd1 == i_raw);
    end
  end

  // stage 4: four table reads, one per table copy; writes land at the same
  // stage so every query sees exactly the writes that came before it
  logic signed [31:0] table_mem0 [TABLE_DEPTH];
  logic signed [31:0] table_mem1 [TABLE_DEPTH];
  logic signed [31:0] table_mem2 [TABLE_DEPTH];
  logic signed [31:0] table_mem3 [TABLE_DEPTH];
  logic signed [31:0] r0, r1, r2, r3;
  op_t             s4_op;
  status_t         s4_st;
  logic [FRAC_BITS:0] s4_f;
  logic            s4_first, s4_lastiv;
  logic [AW-1:0]   a0, a2, a3;
  logic [AW-1:0]   wr_addr;
  logic            tbl_we;
  assign a0 = s3_first ? s3_i : s3_i - AW'(1);
  assign a2 = s3_i + AW'(1);
  assign a3 = s3_lastiv ? a2 : s3_i + AW'(2);
  assign wr_addr = AW'(s3_sidx);
  assign tbl_we  = en && vld[2] && s3_op == OP_WRITE && s3_st == ST_OK;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_mem0[wr_addr] <= s3_sval;
      table_mem1[wr_addr] <= s3_sval;
      table_mem2[wr_addr] <= s3_sval;
      table_mem3[wr_addr] <= s3_sval;
    end
    if (en) begin
      r0 <= table_mem0[a0];
      r1 <= table_mem1[s3_i];
      r2 <= table_mem2[a2];
      r3 <= table_mem3[a3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_op <= s3_op; s4_st <= s3_st; s4_f <= s3_f;
      s4_first <= s3_first; s4_lastiv <= s3_lastiv;
    end
  end

  // stage 5: edge extrapolation and polynomial coefficients
  logic signed [XW-1:0] p0, p1, p2, p3;
  always_comb begin
    p1 = XW'(r1);
    p2 = XW'(r2);
    p0 = s4_first  ? 2 * p1 - p2 : XW'(r0);
    p3 = s4_lastiv ? 2 * p2 - p1 : XW'(r3);
  end

  op_t s5_op; status_t s5_st; logic [FRAC_BITS:0] s5_f;
  logic signed [XW-1:0] s5_a, s5_b, s5_c, s5_p1;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_op <= s4_op; s5_st <= s4_st; s5_f <= s4_f; s5_p1 <= p1;
      s5_a <= p2 - p0;
      s5_b <= 2 * p0 - 5 * p1 + 4 * p2 - p3;
      s5_c <= 3 * (p1 - p2) + p3 - p0;
    end
  end

  // stages 6..8: horner chain, one fraction multiply per stage
  logic signed [XW-1:0] m1_x, m1_y, m2_x, m2_y, m3_x, m3_y;
  op_t s6_op, s7_op, s8_op;
  status_t s6_st, s7_st, s8_st;
  logic [FRAC_BITS:0] s6_f, s7_f;
  logic signed [XW-1:0] s6_a, s6_b, s6_p1, s7_a, s7_p1;

  assign m1_x = (s5_op == OP_VALUE) ? s5_c : 3 * s5_c;
  ugci_mulfrac #(.XW(XW), .FB(FRAC_BITS)) u_m1 (.clk, .en, .x(m1_x), .f(s5_f), .y(m1_y));
  always_ff @(posedge clk) begin
    if (en) begin
      s6_op <= s5_op; s6_st <= s5_st; s6_f <= s5_f;
      s6_a <= s5_a; s6_b <= s5_b; s6_p1 <= s5_p1;
    end
  end

  assign m2_x = ((s6_op == OP_VALUE) ? s6_b : 2 * s6_b) + m1_y;
  ugci_mulfrac #(.XW(XW), .FB(FRAC_BITS)) u_m2 (.clk, .en, .x(m2_x), .f(s6_f), .y(m2_y));
  always_ff @(posedge clk) begin
    if (en) begin
      s7_op <= s6_op; s7_st <= s6_st; s7_f <= s6_f;
      s7_a <= s6_a; s7_p1 <= s6_p1;
    end
  end

  // value multiplies once more; slope passes a + m2 through the same slot
  assign m3_x = s7_a + m2_y;
  ugci_mulfrac #(.XW(XW), .FB(FRAC_BITS)) u_m3 (.clk, .en, .x(m3_x),
    .f((s7_op == OP_VALUE) ? s7_f : (FRAC_BITS+1)'(1) << FRAC_BITS), .y(m3_y));
  logic signed [XW-1:0] s8_p1;
  always_ff @(posedge clk) begin
    if (en) begin
      s8_op <= s7_op; s8_st <= s7_st; s8_p1 <= s7_p1;
    end
  end

  // stage 9: halve toward zero, add p1 for values, saturate; zero for errors and non-queries
  logic signed [XW-1:0] half, rsum;
  logic signed [31:0]   rsat;
  assign half = (m3_y + $signed(XW'(m3_y[XW-1]))) >>> 1;
  assign rsum = (s8_op == OP_VALUE) ? s8_p1 + half : half;
  always_comb begin
    if (rsum > XW'(32'sh7fffffff)) rsat = 32'sh7fffffff;
    else if (rsum < -XW'(64'sh80000000)) rsat = 32'sh80000000;
    else rsat = rsum[31:0];
    if (!(s8_op == OP_VALUE || s8_op == OP_SLOPE) || s8_st != ST_OK) rsat = '0;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NS-2:0], acc};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (en) out_full <= vld[NS-1];
  end
  logic [33:0] out_data;
  always_ff @(posedge clk) begin
    if (en) out_data <= {s8_st, rsat};
  end
  assign m_tvalid = out_full;
  assign m_tdata  = {6'd0, out_data};

  // a stalled output holds its data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && m_tvalid) else $error("output changed");
  // writes never report outside grid
  a_wst: assert property (@(posedge clk) disable iff (rst)
    en && s1_op == OP_WRITE |-> s1_st != ST_OUTSIDE) else $error("write status");
  // error results carry zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33:32] != 2'd0 |-> m_tdata[31:0] == 32'd0) else $error("nonzero");
endmodule

@@ bench/uniform_grid_cubic_interpolator_top_test.sv @@
// self-checking stream testbench for the uniform grid cubic interpolator
`timescale 1ns / 1ps

module uniform_grid_cubic_interpolator_top_test;
  import ugci_pkg::*;

  localparam int DEPTH      = 1024;
  localparam int FRAC       = 16;
  localparam int SETTLE     = 12;    // settling margin after the drain
  localparam int STUCK_MAX  = 5000;  // cycles with no transaction before giving up
  localparam int RAND_PHASE = 72;    // random items per configuration phase
  localparam int FILL       = 256;   // low rows loaded before the random phases
  localparam longint FILL_SPAN = longint'(FILL - 3) << FRAC;

  typedef struct {
    op_t         op;
    logic [9:0]  idx;
    logic [31:0] sample;
    logic [31:0] pos;
  } grid_item_t;

  typedef struct {
    logic [31:0] value;
    status_t     status;
  } interp_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_GRID_MIN;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  uniform_grid_cubic_interpolator_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  // predictor copy of the registers and the sample table
  logic signed [31:0] grid_min_q;
  logic [31:0]        inv_spacing_q;
  logic [10:0]        point_count_q;
  logic signed [31:0] samples [DEPTH];
  // rows that queued writes have loaded, tracked while items are generated
  bit                 written [DEPTH];

  grid_item_t     pending_items [$];
  interp_result_t awaited_results [$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int outside_seen = 0;
  int badidx_seen = 0;
  int query_count = 0;
  int stuck_cycles = 0;

  function automatic longint clamp_count(logic [10:0] cnt);
    if (cnt < 5) return 5;
    if (cnt > DEPTH) return DEPTH;
    return longint'(cnt);
  endfunction

  // x * f / 2^FRAC truncated toward zero
  function automatic longint frac_mul(longint x, longint f);
    longint unsigned m;
    longint unsigned r;
    m = (x < 0) ? -x : x;
    r = (m >> FRAC) * f + (((m & 64'hFFFF) * f) >> FRAC);
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic interp_result_t interp_predict(grid_item_t it);
    interp_result_t res;
    longint n, diff, i, f, p0, p1, p2, p3, a, b, c, r;
    logic [63:0] t;
    res.value = '0;
    res.status = ST_OK;
    n = clamp_count(point_count_q);
    case (it.op)
      OP_WRITE: begin
        if (it.idx >= n) res.status = ST_BADIDX;
        else samples[it.idx] = it.sample;
      end
      OP_NONE: ;
      default: begin
        diff = longint'($signed(it.pos)) - longint'(grid_min_q);
        t = 64'(diff) * {32'b0, inv_spacing_q};
        t = t >> FRAC;
        if (diff < 0 || t > 64'((n - 1) << FRAC)) begin
          res.status = ST_OUTSIDE;
        end else begin
          i = t >> FRAC;
          f = t & 64'hFFFF;
          // last grid point: last interval with a fraction of one
          if (i == n - 1) begin
            i = i - 1;
            f = longint'(1) << FRAC;
          end
          p1 = longint'(samples[i]);
          p2 = longint'(samples[i + 1]);
          if (i == 0) begin
            p0 = 2 * p1 - p2;
            p3 = longint'(samples[i + 2]);
          end else if (i == n - 2) begin
            p0 = longint'(samples[i - 1]);
            p3 = 2 * p2 - p1;
          end else begin
            p0 = longint'(samples[i - 1]);
            p3 = longint'(samples[i + 2]);
          end
          a = p2 - p0;
          b = 2 * p0 - 5 * p1 + 4 * p2 - p3;
          c = 3 * (p1 - p2) + p3 - p0;
          if (it.op == OP_VALUE) r = p1 + frac_mul(a + frac_mul(b + frac_mul(c, f), f), f) / 2;
          else r = (a + frac_mul(2 * b + frac_mul(3 * c, f), f)) / 2;
          if (r > 64'sd2147483647) r = 64'sd2147483647;
          if (r < -64'sd2147483648) r = -64'sd2147483648;
          res.value = r[31:0];
        end
      end
    endcase
    return res;
  endfunction

  // driver: pops pending items, random gaps with occasional back-to-back stretches
  int  send_gap = 0;
  bit  send_burst = 0;
  grid_item_t driven;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_results.push_back(interp_predict(driven));
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          driven = pending_items.pop_front();
          s_tdata <= {4'b0, driven.pos, driven.sample, driven.idx, driven.op};
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 40) == 0) send_burst = ~send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 16);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, in-order comparison against predictions
  int  recv_stall = 0;
  bit  recv_burst = 0;
  interp_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, actual value %h status %0d",
                   $time, m_tdata[31:0], m_tdata[33:32]);
        end else begin
          want = awaited_results.pop_front();
          if (want.status == ST_OUTSIDE) outside_seen++;
          if (want.status == ST_BADIDX) badidx_seen++;
          if (m_tdata[31:0] !== want.value) begin
            errors++;
            $display("%0t: result_value mismatch, expected %h actual %h",
                     $time, want.value, m_tdata[31:0]);
          end
          if (m_tdata[33:32] !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, m_tdata[33:32]);
          end
        end
        if ($urandom_range(0, 40) == 0) recv_burst = ~recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 16);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_MAX) begin
      $display("%0t: no progress, %0d results still awaited", $time, awaited_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // waits until every item went through and every result arrived
  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() > 0 || s_tvalid || awaited_results.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_GRID_MIN: grid_min_q = data;
      REG_INV_SPC:  inv_spacing_q = data;
      REG_COUNT:    point_count_q = data[10:0];
      default: ;
    endcase
  endtask

  task automatic reconfigure(logic [31:0] gmin, logic [31:0] inv, logic [10:0] cnt);
    drain();
    write_reg(REG_GRID_MIN, gmin);
    write_reg(REG_INV_SPC, inv);
    write_reg(REG_COUNT, {21'b0, cnt});
  endtask

  task automatic add_item(op_t op, logic [9:0] idx, logic [31:0] sample, logic [31:0] pos);
    grid_item_t it;
    it.op = op;
    it.idx = idx;
    it.sample = sample;
    it.pos = pos;
    if (op == OP_VALUE || op == OP_SLOPE) query_count++;
    if (op == OP_WRITE && longint'(idx) < clamp_count(point_count_q)) written[idx] = 1'b1;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  // mostly positions inside the grid, with edges, the last point and outliers
  function automatic logic [31:0] pick_position();
    longint n, span, tt, d, p;
    int sel;
    n = clamp_count(point_count_q);
    span = (n - 1) << FRAC;
    sel = $urandom_range(0, 99);
    if (sel < 5) return $urandom;
    if (sel < 10) begin
      p = longint'(grid_min_q) - 1 - $urandom_range(0, 1000);
    end else begin
      if (sel < 16) tt = span;
      else if (sel < 22) tt = span + $urandom_range(1, 65536);
      else if (sel < 28) tt = $urandom_range(0, 3 << FRAC);
      else tt = longint'($urandom) % (((span < FILL_SPAN) ? span : FILL_SPAN) + 1);
      if (inv_spacing_q == 0) d = tt >> FRAC;
      else d = ((tt << FRAC) + inv_spacing_q - 1) / inv_spacing_q;
      p = longint'(grid_min_q) + d;
    end
    if (p > 64'sd2147483647 || p < -64'sd2147483648) return $urandom;
    return p[31:0];
  endfunction

  // true when a query at pos lies outside the grid or reads only rows that have been loaded
  function automatic bit rows_written(logic [31:0] pos);
    longint n, diff, i;
    logic [63:0] t;
    bit ok;
    n = clamp_count(point_count_q);
    diff = longint'($signed(pos)) - longint'(grid_min_q);
    if (diff < 0) return 1'b1;
    t = (64'(diff) * {32'b0, inv_spacing_q}) >> FRAC;
    if (t > 64'((n - 1) << FRAC)) return 1'b1;
    i = longint'(t >> FRAC);
    if (i == n - 1) i = i - 1;
    ok = written[i] && written[i + 1];
    if (i != 0) ok = ok && written[i - 1];
    if (i != n - 2) ok = ok && written[i + 2];
    return ok;
  endfunction

  task automatic random_phase(int count);
    int sel;
    op_t op;
    logic [31:0] pos;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        add_item(OP_WRITE, 10'($urandom_range(0, DEPTH - 1)), random_sample(), $urandom);
      end else if (sel < 96) begin
        op = (sel < 58) ? OP_VALUE : OP_SLOPE;
        pos = pick_position();
        // retry a position that would touch unloaded rows, then give up on it
        repeat (4) if (!rows_written(pos)) pos = pick_position();
        if (rows_written(pos)) add_item(op, 10'($urandom), $urandom, pos);
        else add_item(OP_NONE, 10'($urandom), $urandom, pos);
      end else begin
        add_item(OP_NONE, 10'($urandom), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    grid_min_q = 0;
    inv_spacing_q = 32'h0001_0000;
    point_count_q = 11'd5;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: reset configuration, five points loaded with extreme samples
    add_item(OP_WRITE, 10'd0, 32'h8000_0000, 32'h0);
    add_item(OP_WRITE, 10'd1, 32'h7FFF_FFFF, 32'h0);
    add_item(OP_WRITE, 10'd2, 32'h0000_0000, 32'h0);
    add_item(OP_WRITE, 10'd3, 32'hFFFF_FFFF, 32'h0);
    add_item(OP_WRITE, 10'd4, 32'h0001_0000, 32'h0);
    add_item(OP_WRITE, 10'd5, 32'h1234_5678, 32'h0);         // past point count
    add_item(OP_WRITE, 10'd1023, 32'h7FFF_FFFF, 32'h0);      // past point count
    add_item(OP_NONE, 10'd3, 32'hFFFF_FFFF, 32'h0001_8000);  // unused code
    add_item(OP_VALUE, 10'd0, 32'h0, 32'hFFFF_FFFF);         // just below grid_min
    add_item(OP_VALUE, 10'd0, 32'h0, 32'h0000_0000);         // first point, left edge
    add_item(OP_VALUE, 10'd0, 32'h0, 32'h0001_8000);
    add_item(OP_VALUE, 10'd0, 32'h0, 32'h0003_8000);         // right edge interval
    add_item(OP_VALUE, 10'd0, 32'h0, 32'h0004_0000);         // exactly the last point
    add_item(OP_VALUE, 10'd0, 32'h0, 32'h0004_0001);         // just past the grid
    add_item(OP_SLOPE, 10'd0, 32'h0, 32'h0000_0000);
    add_item(OP_SLOPE, 10'd0, 32'h0, 32'h0002_8000);
    add_item(OP_SLOPE, 10'd0, 32'h0, 32'h0003_8000);
    add_item(OP_SLOPE, 10'd0, 32'h0, 32'h0004_0000);
    add_item(OP_SLOPE, 10'd0, 32'h0, 32'h7FFF_FFFF);
    add_item(OP_SLOPE, 10'd0, 32'h0, 32'h8000_0000);

    // load the low rows and the top rows; queries only land on loaded rows
    reconfigure(32'h0, 32'h0001_0000, 11'd1024);
    for (int k = 0; k < FILL; k++) add_item(OP_WRITE, 10'(k), random_sample(), $urandom);
    for (int k = DEPTH - 4; k < DEPTH; k++)
      add_item(OP_WRITE, 10'(k), random_sample(), $urandom);

    random_phase(RAND_PHASE);
    reconfigure(32'h8000_0000, 32'hFFFF_FFFF, 11'd1024);
    random_phase(RAND_PHASE);
    reconfigure(32'h7FFF_0000, $urandom_range(32'h4000, 32'h40000), 11'd5);
    random_phase(RAND_PHASE);
    reconfigure($urandom, 32'h0000_0001, 11'($urandom_range(5, FILL)));
    random_phase(RAND_PHASE);
    // zero spacing and a count below the minimum
    reconfigure($urandom, 32'h0, 11'd0);
    random_phase(RAND_PHASE);
    // count above the table depth
    reconfigure($urandom, $urandom, 11'd2047);
    random_phase(RAND_PHASE);
    reconfigure(32'hFFFB_0000, $urandom_range(32'h4000, 32'h40000),
                11'($urandom_range(5, FILL)));
    random_phase(RAND_PHASE);
    reconfigure($urandom_range(0, 32'h00FF_FFFF), 32'h0001_0000, 11'd1024);
    random_phase(RAND_PHASE);

    drain();
    if (awaited_results.size() > 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
    end
    $display("covered %0d input transactions (%0d queries) over 9 register settings",
             items_sent, query_count);
    $display("checked %0d results: %0d outside grid, %0d rejected writes, %0d errors",
             results_seen, outside_seen, badidx_seen, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
